FILE: rtl/core/register_rename_reorder_buffer_defines.svh
// ----------------------------------------------------------------------------
// Register rename and reorder buffer: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef REGISTER_RENAME_REORDER_BUFFER_DEFINES_SVH
`define REGISTER_RENAME_REORDER_BUFFER_DEFINES_SVH

// same-cycle implication
`define RROB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RROB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/rrob_pkg.sv
// ----------------------------------------------------------------------------
// Register rename and reorder buffer: package
// Default sizes, field widths, operation and register codes, shared types.
// ----------------------------------------------------------------------------
package rrob_pkg;

   localparam int ROB_DEPTH_DEF = 64;
   localparam int ARCH_REGS_DEF = 67;
   localparam int MAX_WIDTH_DEF = 8;

   localparam int TAG_W  = 6;
   localparam int REG_W  = 8;
   localparam int DEST_W = 7;
   localparam int PC_W   = 32;
   localparam int CSR_W  = 7;

   localparam logic [DEST_W-1:0] NO_REG   = 7'h7F;
   localparam logic [REG_W-1:0]  NONE_OUT = 8'hFF;

   localparam logic [1:0] OP_RENAME    = 2'd0;
   localparam logic [1:0] OP_WRITEBACK = 2'd1;
   localparam logic [1:0] OP_RETIRE    = 2'd2;

   localparam logic CSR_ENTRIES = 1'b0;
   localparam logic CSR_WIDTH   = 1'b1;

   typedef struct packed {
      logic ent_we;
      logic map_we;
   } mem_ctl_type;

endpackage

FILE: rtl/core/rrob_mem.sv
// ----------------------------------------------------------------------------
// Register rename and reorder buffer: table storage
// Entry destination and address memory, and the map tag memory with two reads.
// ----------------------------------------------------------------------------
module rrob_mem
   import rrob_pkg::*;
#(
   parameter int ROB_DEPTH = ROB_DEPTH_DEF,
   parameter int ARCH_REGS = ARCH_REGS_DEF,
   localparam int PW = $clog2(ROB_DEPTH),
   localparam int AW = $clog2(ARCH_REGS)
) (
   input  logic              clock,
   input  mem_ctl_type       ctl,
   input  logic [PW-1:0]     ent_waddr,
   input  logic [DEST_W-1:0] ent_wdest,
   input  logic [PC_W-1:0]   ent_wpc,
   input  logic [PW-1:0]     ent_raddr,
   output logic [DEST_W-1:0] ent_rdest,
   output logic [PC_W-1:0]   ent_rpc,
   input  logic [AW-1:0]     map_waddr,
   input  logic [PW-1:0]     map_wtag,
   input  logic [AW-1:0]     map_raddr_a,
   input  logic [AW-1:0]     map_raddr_b,
   output logic [PW-1:0]     map_rdata_a,
   output logic [PW-1:0]     map_rdata_b
);

   logic [DEST_W-1:0] dest_mem [ROB_DEPTH];
   logic [PC_W-1:0]   pc_mem   [ROB_DEPTH];
   logic [PW-1:0]     tag_mem  [ARCH_REGS];

   always_ff @(posedge clock) begin
      if (ctl.ent_we) begin
         dest_mem[ent_waddr] <= ent_wdest;
         pc_mem[ent_waddr]   <= ent_wpc;
      end
      ent_rdest <= dest_mem[ent_raddr];
      ent_rpc   <= pc_mem[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (ctl.map_we) begin
         tag_mem[map_waddr] <= map_wtag;
      end
      map_rdata_a <= tag_mem[map_raddr_a];
      map_rdata_b <= tag_mem[map_raddr_b];
   end

endmodule

FILE: rtl/core/register_rename_reorder_buffer.sv
// ----------------------------------------------------------------------------
// Register rename and reorder buffer
// Rename map table with a circular reorder buffer, run by a small sequencer.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Rename goes through
// a map read, then a table update; writeback and unused operations answer
// with busy staying low. Retire frees entries one at a time: each entry
// costs an entry memory read, a map tag read and an update through the
// one retire step. Every result is shown for exactly one cycle with
// rsp_valid high and cannot be held off; rsp_last_result marks the final
// result of an item. Write the CSRs only while idle; a write of the entry
// count empties the buffer and the map at once, no clearing pass.
// ----------------------------------------------------------------------------
`include "register_rename_reorder_buffer_defines.svh"

module register_rename_reorder_buffer
   import rrob_pkg::*;
#(
   parameter int ROB_DEPTH = ROB_DEPTH_DEF,
   parameter int ARCH_REGS = ARCH_REGS_DEF,
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_operation,
   input  logic signed [REG_W-1:0] req_src1_reg,
   input  logic signed [REG_W-1:0] req_src2_reg,
   input  logic signed [REG_W-1:0] req_dest_reg,
   input  logic [PC_W-1:0]         req_instr_pc,
   input  logic [TAG_W-1:0]        req_done_tag,
   output logic                    rsp_valid,
   output logic                    rsp_accepted,
   output logic [TAG_W-1:0]        rsp_src1_tag,
   output logic                    rsp_src1_ready,
   output logic [TAG_W-1:0]        rsp_src2_tag,
   output logic                    rsp_src2_ready,
   output logic [TAG_W-1:0]        rsp_dest_tag,
   output logic                    rsp_retire_valid,
   output logic [TAG_W-1:0]        rsp_retire_tag,
   output logic signed [REG_W-1:0] rsp_retire_dest,
   output logic [PC_W-1:0]         rsp_retire_pc,
   output logic                    rsp_last_result,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [CSR_W-1:0]        csr_wdata
);

   localparam int PW = $clog2(ROB_DEPTH);
   localparam int CW = $clog2(ROB_DEPTH + 1);
   localparam int AW = $clog2(ARCH_REGS);
   localparam int NW = $clog2(MAX_WIDTH + 1);
   localparam int RST_ENTRIES = (ROB_DEPTH < 64) ? ROB_DEPTH : 64;
   localparam int RST_WIDTH   = (MAX_WIDTH < 4) ? MAX_WIDTH : 4;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_REN  = 3'd1;
   localparam logic [2:0] S_CHK  = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_UPD  = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [CW-1:0]        entries_ff, entries_in;
   logic [NW-1:0]        width_ff, width_in;
   logic [PW-1:0]        head_ff, head_in;
   logic [PW-1:0]        tail_ff, tail_in;
   logic [CW-1:0]        free_ff, free_in;
   logic [NW-1:0]        cnt_ff, cnt_in;
   logic [ROB_DEPTH-1:0] ebusy_ff, ebusy_in;
   logic [ROB_DEPTH-1:0] eready_ff, eready_in;
   logic [ARCH_REGS-1:0] mvalid_ff, mvalid_in;

   logic [AW-1:0]        s1_idx_ff, s1_idx_in, s2_idx_ff, s2_idx_in;
   logic                 s1_ok_ff, s1_ok_in, s2_ok_ff, s2_ok_in;
   logic [DEST_W-1:0]    d_ff, d_in;
   logic [PC_W-1:0]      pc_ff, pc_in;
   logic [TAG_W-1:0]     pend_tag_ff, pend_tag_in;
   logic [REG_W-1:0]     pend_dest_ff, pend_dest_in;
   logic [PC_W-1:0]      pend_pc_ff, pend_pc_in;

   logic                 rv_ff, rv_in;
   logic                 acc_ff, acc_in;
   logic [TAG_W-1:0]     t1_ff, t1_in, t2_ff, t2_in, dt_ff, dt_in;
   logic                 r1_ff, r1_in, r2_ff, r2_in;
   logic                 ret_ff, ret_in;
   logic [TAG_W-1:0]     rtag_ff, rtag_in;
   logic [REG_W-1:0]     rdest_ff, rdest_in;
   logic [PC_W-1:0]      rpc_ff, rpc_in;
   logic                 last_ff, last_in;

   mem_ctl_type          mctl;
   logic [DEST_W-1:0]    ent_rdest;
   logic [PC_W-1:0]      ent_rpc;
   logic [AW-1:0]        map_raddr_a;
   logic [PW-1:0]        map_rdata_a, map_rdata_b;

   logic                 src1_ok, src2_ok, dst_ok;
   logic [CW-1:0]        head_inc, tail_inc;
   logic [PW-1:0]        head_nx, tail_nx;
   logic                 can_retire, wb_ok, d_in_range, map_hit;
   logic [AW-1:0]        d_idx;
   logic [31:0]          cfg_entries, cfg_width;
   int                   used_total;

   assign src1_ok = !req_src1_reg[REG_W-1] && (32'(req_src1_reg[REG_W-2:0]) < ARCH_REGS);
   assign src2_ok = !req_src2_reg[REG_W-1] && (32'(req_src2_reg[REG_W-2:0]) < ARCH_REGS);
   assign dst_ok  = !req_dest_reg[REG_W-1] && (32'(req_dest_reg[REG_W-2:0]) < ARCH_REGS);

   assign head_inc = CW'(head_ff) + CW'(1);
   assign tail_inc = CW'(tail_ff) + CW'(1);
   assign head_nx  = (head_inc >= entries_ff) ? '0 : PW'(head_inc);
   assign tail_nx  = (tail_inc >= entries_ff) ? '0 : PW'(tail_inc);

   assign can_retire = (cnt_ff < width_ff) && ebusy_ff[head_ff] && eready_ff[head_ff];
   assign wb_ok      = (32'(req_done_tag) < 32'(entries_ff)) && ebusy_ff[PW'(req_done_tag)];

   assign d_idx      = AW'(ent_rdest);
   assign d_in_range = (ent_rdest != NO_REG) && (32'(ent_rdest) < ARCH_REGS);
   assign map_hit    = d_in_range && mvalid_ff[d_idx] && (map_rdata_a == head_ff);

   assign map_raddr_a = (state_ff == S_IDLE) ? AW'(req_src1_reg[REG_W-2:0]) : d_idx;

   assign cfg_entries = (csr_wdata == '0) ? 32'd1 :
                        (32'(csr_wdata) > ROB_DEPTH) ? 32'(ROB_DEPTH) : 32'(csr_wdata);
   assign cfg_width   = (csr_wdata[3:0] == '0) ? 32'd1 :
                        (32'(csr_wdata[3:0]) > MAX_WIDTH) ? 32'(MAX_WIDTH) :
                        32'(csr_wdata[3:0]);

   assign used_total = $countones(ebusy_ff) + int'(free_ff);

   always_comb begin
      state_in     = state_ff;
      entries_in   = entries_ff;
      width_in     = width_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      free_in      = free_ff;
      cnt_in       = cnt_ff;
      ebusy_in     = ebusy_ff;
      eready_in    = eready_ff;
      mvalid_in    = mvalid_ff;
      s1_idx_in    = s1_idx_ff;
      s2_idx_in    = s2_idx_ff;
      s1_ok_in     = s1_ok_ff;
      s2_ok_in     = s2_ok_ff;
      d_in         = d_ff;
      pc_in        = pc_ff;
      pend_tag_in  = pend_tag_ff;
      pend_dest_in = pend_dest_ff;
      pend_pc_in   = pend_pc_ff;
      rv_in        = 1'b0;
      acc_in       = 1'b0;
      t1_in        = '0;
      r1_in        = 1'b0;
      t2_in        = '0;
      r2_in        = 1'b0;
      dt_in        = '0;
      ret_in       = 1'b0;
      rtag_in      = '0;
      rdest_in     = '0;
      rpc_in       = '0;
      last_in      = 1'b0;
      mctl         = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_operation)
                  OP_RENAME: begin
                     s1_idx_in = AW'(req_src1_reg[REG_W-2:0]);
                     s2_idx_in = AW'(req_src2_reg[REG_W-2:0]);
                     s1_ok_in  = src1_ok;
                     s2_ok_in  = src2_ok;
                     d_in      = dst_ok ? req_dest_reg[DEST_W-1:0] : NO_REG;
                     pc_in     = req_instr_pc;
                     state_in  = S_REN;
                  end
                  OP_WRITEBACK: begin
                     rv_in   = 1'b1;
                     last_in = 1'b1;
                     if (wb_ok) begin
                        eready_in[PW'(req_done_tag)] = 1'b1;
                        acc_in = 1'b1;
                     end
                  end
                  OP_RETIRE: begin
                     cnt_in   = '0;
                     state_in = S_CHK;
                  end
                  default: begin
                     rv_in   = 1'b1;
                     last_in = 1'b1;
                  end
               endcase
            end
         end
         S_REN: begin
            rv_in    = 1'b1;
            last_in  = 1'b1;
            state_in = S_IDLE;
            if (free_ff != '0) begin
               acc_in = 1'b1;
               if (s1_ok_ff && mvalid_ff[s1_idx_ff]) begin
                  t1_in = TAG_W'(map_rdata_a);
               end else begin
                  r1_in = 1'b1;
               end
               if (s2_ok_ff && mvalid_ff[s2_idx_ff]) begin
                  t2_in = TAG_W'(map_rdata_b);
               end else begin
                  r2_in = 1'b1;
               end
               dt_in = TAG_W'(tail_ff);
               if (d_ff != NO_REG) begin
                  mvalid_in[AW'(d_ff)] = 1'b1;
                  mctl.map_we = 1'b1;
               end
               mctl.ent_we        = 1'b1;
               ebusy_in[tail_ff]  = 1'b1;
               eready_in[tail_ff] = 1'b0;
               tail_in            = tail_nx;
               free_in            = free_ff - CW'(1);
            end
         end
         S_CHK: begin
            if (!can_retire || cnt_ff != '0) begin
               rv_in   = 1'b1;
               last_in = !can_retire;
               if (cnt_ff != '0) begin
                  ret_in   = 1'b1;
                  rtag_in  = pend_tag_ff;
                  rdest_in = pend_dest_ff;
                  rpc_in   = pend_pc_ff;
               end
            end
            state_in = can_retire ? S_RD : S_IDLE;
         end
         S_RD: begin
            state_in = S_UPD;
         end
         S_UPD: begin
            pend_tag_in  = TAG_W'(head_ff);
            pend_dest_in = (ent_rdest == NO_REG) ? NONE_OUT : {1'b0, ent_rdest};
            pend_pc_in   = ent_rpc;
            if (map_hit) begin
               mvalid_in[d_idx] = 1'b0;
            end
            ebusy_in[head_ff]  = 1'b0;
            eready_in[head_ff] = 1'b0;
            head_in  = head_nx;
            free_in  = free_ff + CW'(1);
            cnt_in   = cnt_ff + NW'(1);
            state_in = S_CHK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_we) begin
         unique case (csr_index)
            CSR_ENTRIES: begin
               entries_in = CW'(cfg_entries);
               free_in    = CW'(cfg_entries);
               head_in    = '0;
               tail_in    = '0;
               ebusy_in   = '0;
               eready_in  = '0;
               mvalid_in  = '0;
            end
            CSR_WIDTH: begin
               width_in = NW'(cfg_width);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         entries_ff <= CW'(RST_ENTRIES);
         width_ff   <= NW'(RST_WIDTH);
         head_ff    <= '0;
         tail_ff    <= '0;
         free_ff    <= CW'(RST_ENTRIES);
         cnt_ff     <= '0;
         ebusy_ff   <= '0;
         eready_ff  <= '0;
         mvalid_ff  <= '0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         entries_ff <= entries_in;
         width_ff   <= width_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         free_ff    <= free_in;
         cnt_ff     <= cnt_in;
         ebusy_ff   <= ebusy_in;
         eready_ff  <= eready_in;
         mvalid_ff  <= mvalid_in;
         rv_ff      <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff    <= s1_idx_in;
      s2_idx_ff    <= s2_idx_in;
      s1_ok_ff     <= s1_ok_in;
      s2_ok_ff     <= s2_ok_in;
      d_ff         <= d_in;
      pc_ff        <= pc_in;
      pend_tag_ff  <= pend_tag_in;
      pend_dest_ff <= pend_dest_in;
      pend_pc_ff   <= pend_pc_in;
      acc_ff       <= acc_in;
      t1_ff        <= t1_in;
      r1_ff        <= r1_in;
      t2_ff        <= t2_in;
      r2_ff        <= r2_in;
      dt_ff        <= dt_in;
      ret_ff       <= ret_in;
      rtag_ff      <= rtag_in;
      rdest_ff     <= rdest_in;
      rpc_ff       <= rpc_in;
      last_ff      <= last_in;
   end

   rrob_mem #(
      .ROB_DEPTH(ROB_DEPTH),
      .ARCH_REGS(ARCH_REGS)
   ) u_mem (
      .clock      (clock),
      .ctl        (mctl),
      .ent_waddr  (tail_ff),
      .ent_wdest  (d_ff),
      .ent_wpc    (pc_ff),
      .ent_raddr  (head_ff),
      .ent_rdest  (ent_rdest),
      .ent_rpc    (ent_rpc),
      .map_waddr  (AW'(d_ff)),
      .map_wtag   (tail_ff),
      .map_raddr_a(map_raddr_a),
      .map_raddr_b(AW'(req_src2_reg[REG_W-2:0])),
      .map_rdata_a(map_rdata_a),
      .map_rdata_b(map_rdata_b)
   );

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rv_ff;
   assign rsp_accepted     = acc_ff;
   assign rsp_src1_tag     = t1_ff;
   assign rsp_src1_ready   = r1_ff;
   assign rsp_src2_tag     = t2_ff;
   assign rsp_src2_ready   = r2_ff;
   assign rsp_dest_tag     = dt_ff;
   assign rsp_retire_valid = ret_ff;
   assign rsp_retire_tag   = rtag_ff;
   assign rsp_retire_dest  = rdest_ff;
   assign rsp_retire_pc    = rpc_ff;
   assign rsp_last_result  = last_ff;

   `RROB_ASSERT_NOW(a_occupancy, clock, reset, 1'b1, used_total == int'(entries_ff), "count drift")
   `RROB_ASSERT_NOW(a_ready_busy, clock, reset, 1'b1, (eready_ff & ~ebusy_ff) == '0, "stray ready")
   `RROB_ASSERT_NOW(a_busy_start, clock, reset, $rose(busy), $past(start), "busy without start")

endmodule
